[hdl/lsbbr_pkg.sv]
// ----------------------------------------------------------------------------
// lsbbr_pkg
// Types, operation codes, register indexes and a helper function shared by the
// bit reader modules.
// ----------------------------------------------------------------------------
package lsbbr_pkg;

  localparam int WINDOW_BITS = 64;

  // Operation codes carried in the item word.
  localparam logic [1:0] OP_FEED  = 2'd0;
  localparam logic [1:0] OP_PEEK  = 2'd1;
  localparam logic [1:0] OP_SHIFT = 2'd2;

  // Configuration register indexes.
  localparam logic REG_BIG_ENDIAN = 1'b0;
  localparam logic REG_FINAL_BITS = 1'b1;

  localparam logic [6:0] FEED_LIMIT_BYTE = 7'(WINDOW_BITS - 8);
  localparam logic [6:0] FEED_LIMIT_WORD = 7'(WINDOW_BITS - 16);

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] source_word;
    logic        is_final_load;
    logic [6:0]  bit_len;
  } item_t;

  typedef struct packed {
    logic        accepted;
    logic [15:0] peek_value;
    logic        short_of_bits;
    logic [6:0]  bits_available;
    logic        overflowed;
    logic        source_end;
    logic [31:0] bytes_read;
  } result_t;

  typedef struct packed {
    logic       big_endian_mode;
    logic [3:0] final_valid_bits;
  } cfg_t;

  // Reverses a 16-bit word end for end.
  function automatic logic [15:0] flip16(input logic [15:0] w);
    logic [15:0] r;
    for (int i = 0; i < 16; i++) begin
      r[15 - i] = w[i];
    end
    return r;
  endfunction

endpackage

[hdl/lsbbr_cfg.sv]
// ----------------------------------------------------------------------------
// lsbbr_cfg
// Configuration registers of the bit reader, written through a plain port.
// ----------------------------------------------------------------------------
module lsbbr_cfg (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic             cfg_index,
  input  logic [3:0]       cfg_data,
  output lsbbr_pkg::cfg_t  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        lsbbr_pkg::REG_BIG_ENDIAN: begin
          cfg.big_endian_mode <= cfg_data[0];
        end
        lsbbr_pkg::REG_FINAL_BITS: begin
          cfg.final_valid_bits <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

[hdl/lsbbr_datapath.sv]
// ----------------------------------------------------------------------------
// lsbbr_datapath
// Bit window state and the combinational feed, peek and shift logic.
// ----------------------------------------------------------------------------
module lsbbr_datapath (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  lsbbr_pkg::item_t   item,
  input  lsbbr_pkg::cfg_t    cfg,
  output lsbbr_pkg::result_t result_next
);

  logic [lsbbr_pkg::WINDOW_BITS-1:0] window;
  logic [6:0]  fill;
  logic        final_seen;
  logic        overflow_flag;
  logic [31:0] byte_counter;

  logic [lsbbr_pkg::WINDOW_BITS-1:0] window_next;
  logic [6:0]  fill_next;
  logic        final_seen_next;
  logic        overflow_flag_next;
  logic [31:0] byte_counter_next;

  logic [4:0]  feed_size;
  logic [4:0]  take;
  logic [6:0]  feed_limit;
  logic [15:0] feed_raw;
  logic [15:0] feed_mask;
  logic [15:0] feed_data;
  logic [15:0] peek_mask;
  logic [32:0] count_sum;
  logic        accepted;
  logic [15:0] peek_value;
  logic        short_of_bits;

  assign feed_size  = cfg.big_endian_mode ? 5'd16 : 5'd8;
  assign feed_limit = cfg.big_endian_mode ? lsbbr_pkg::FEED_LIMIT_WORD
                                          : lsbbr_pkg::FEED_LIMIT_BYTE;

  // The final load keeps only the configured number of bits, never more
  // than the load itself carries.
  always_comb begin
    take = feed_size;
    if (item.is_final_load && cfg.final_valid_bits != 4'd0 &&
        {1'b0, cfg.final_valid_bits} < feed_size) begin
      take = {1'b0, cfg.final_valid_bits};
    end
  end

  assign feed_raw  = cfg.big_endian_mode ? lsbbr_pkg::flip16(item.source_word)
                                         : {8'h00, item.source_word[7:0]};
  assign feed_mask = 16'((17'd1 << take) - 17'd1);
  assign feed_data = feed_raw & feed_mask;

  assign peek_mask = (item.bit_len >= 7'd16) ? 16'hFFFF
                   : 16'((17'd1 << item.bit_len[3:0]) - 17'd1);

  assign count_sum = {1'b0, byte_counter} + (cfg.big_endian_mode ? 33'd2 : 33'd1);

  always_comb begin
    window_next        = window;
    fill_next          = fill;
    final_seen_next    = final_seen;
    overflow_flag_next = overflow_flag;
    byte_counter_next  = byte_counter;
    accepted           = 1'b0;
    peek_value         = '0;
    short_of_bits      = 1'b0;
    case (item.operation)
      lsbbr_pkg::OP_FEED: begin
        if (!final_seen && fill <= feed_limit) begin
          window_next       = window |
                              ({{(lsbbr_pkg::WINDOW_BITS - 16){1'b0}}, feed_data} << fill);
          fill_next         = fill + {2'b00, take};
          final_seen_next   = final_seen | item.is_final_load;
          byte_counter_next = count_sum[32] ? 32'hFFFF_FFFF : count_sum[31:0];
          accepted          = 1'b1;
        end
      end
      lsbbr_pkg::OP_PEEK: begin
        peek_value = window[15:0] & peek_mask;
        if (item.bit_len > fill) begin
          short_of_bits = 1'b1;
          if (final_seen) begin
            overflow_flag_next = 1'b1;
          end
        end
        accepted = 1'b1;
      end
      lsbbr_pkg::OP_SHIFT: begin
        if (fill > item.bit_len) begin
          window_next = window >> item.bit_len;
          fill_next   = fill - item.bit_len;
        end else begin
          window_next = '0;
          fill_next   = '0;
        end
        accepted = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window        <= '0;
      fill          <= '0;
      final_seen    <= 1'b0;
      overflow_flag <= 1'b0;
      byte_counter  <= '0;
    end else if (step) begin
      window        <= window_next;
      fill          <= fill_next;
      final_seen    <= final_seen_next;
      overflow_flag <= overflow_flag_next;
      byte_counter  <= byte_counter_next;
    end
  end

  assign result_next.accepted       = accepted;
  assign result_next.peek_value     = peek_value;
  assign result_next.short_of_bits  = short_of_bits;
  assign result_next.bits_available = fill_next;
  assign result_next.overflowed     = overflow_flag_next;
  assign result_next.source_end     = final_seen_next && (fill_next == 7'd0);
  assign result_next.bytes_read     = byte_counter_next;

endmodule

[hdl/lsb_first_bit_reader.sv]
// ----------------------------------------------------------------------------
// lsb_first_bit_reader
// Least-significant-bit-first bit reader with a 64-bit window.
// ----------------------------------------------------------------------------
// Each item word asks for one operation: feed a byte (or a bit-reversed
// 16-bit word in big-endian mode), peek up to 16 low bits, or shift bits out.
// Every item gives exactly one result word with the outcome and the window
// status after the operation.
// Both channels use valid and stall; a word moves when valid is high and
// stall is low. An accepted item is held in an input register, processed
// from there and written to the result register once that register is free
// or emptying. One item is taken every cycle while the result side does not
// stall; the whole operation is a single pass of logic on the window register.
// While the result register is full and stalled, the input register holds
// its item and item_stall is raised; nothing is lost or repeated.
// Reset clears the window, fill, flags, byte counter and configuration.
// Configuration is written through cfg_write, cfg_index and cfg_data; the user
// must do so only while the block is idle, the block does not enforce it.
// ----------------------------------------------------------------------------
module lsb_first_bit_reader (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  lsbbr_pkg::item_t   item,
  output logic               result_valid,
  input  logic               result_stall,
  output lsbbr_pkg::result_t result,
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [3:0]         cfg_data
);

  lsbbr_pkg::item_t   item_q;
  logic               item_q_valid;
  logic               advance;
  lsbbr_pkg::cfg_t    cfg;
  lsbbr_pkg::result_t result_next;

  // The held item moves on whenever the result register is free or emptying.
  assign advance    = item_q_valid && (!result_valid || !result_stall);
  assign item_stall = item_q_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_q_valid <= 1'b0;
    end else if (!item_stall) begin
      item_q_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!item_stall && item_valid) begin
      item_q <= item;
    end
  end

  lsbbr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lsbbr_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .step        (advance),
    .item        (item_q),
    .cfg         (cfg),
    .result_next (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

endmodule

[bench/bit_window_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bit_window_checker
// Watches the item, result and configuration ports of the bit reader, keeps
// its own copy of the window and flags, and compares every result word with
// the expected one.
// ----------------------------------------------------------------------------
module bit_window_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  input  logic               item_stall,
  input  lsbbr_pkg::item_t   item,
  input  logic               result_valid,
  input  logic               result_stall,
  input  lsbbr_pkg::result_t result,
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [3:0]         cfg_data,
  output int                 error_count,
  output int                 words_due
);

  logic        big_endian;
  logic [3:0]  last_load_bits;
  logic [63:0] window;
  logic [6:0]  fill;
  logic        end_marked;
  logic        overflow_seen;
  logic [31:0] byte_total;
  lsbbr_pkg::result_t expected_words[$];

  // Applies one item word to the local window and gives the result it causes.
  task automatic advance_window(input lsbbr_pkg::item_t w, output lsbbr_pkg::result_t r);
    logic [15:0] data;
    logic [4:0]  size;
    logic [4:0]  take;
    logic [4:0]  width;
    logic [31:0] mask;
    logic [31:0] nbytes;
    r = '0;
    case (w.operation)
      lsbbr_pkg::OP_FEED: begin
        size = big_endian ? 5'd16 : 5'd8;
        nbytes = big_endian ? 32'd2 : 32'd1;
        if (!end_marked && int'(fill) + int'(size) <= lsbbr_pkg::WINDOW_BITS) begin
          if (big_endian) begin
            for (int i = 0; i < 16; i++) begin
              data[15 - i] = w.source_word[i];
            end
          end else begin
            data = {8'd0, w.source_word[7:0]};
          end
          // The final load may carry fewer bits than a full feed.
          take = size;
          if (w.is_final_load && last_load_bits != 4'd0 && {1'b0, last_load_bits} < size) begin
            take = {1'b0, last_load_bits};
          end
          mask = (32'd1 << take) - 32'd1;
          data = data & mask[15:0];
          window = window | ({48'd0, data} << fill);
          fill = fill + {2'd0, take};
          if (w.is_final_load) begin
            end_marked = 1'b1;
          end
          if (byte_total > 32'hFFFF_FFFF - nbytes) begin
            byte_total = 32'hFFFF_FFFF;
          end else begin
            byte_total = byte_total + nbytes;
          end
          r.accepted = 1'b1;
        end
      end
      lsbbr_pkg::OP_PEEK: begin
        width = (w.bit_len > 7'd16) ? 5'd16 : w.bit_len[4:0];
        mask = (32'd1 << width) - 32'd1;
        r.peek_value = window[15:0] & mask[15:0];
        if (w.bit_len > fill) begin
          r.short_of_bits = 1'b1;
          if (end_marked) begin
            overflow_seen = 1'b1;
          end
        end
        r.accepted = 1'b1;
      end
      lsbbr_pkg::OP_SHIFT: begin
        if (fill > w.bit_len) begin
          window = window >> w.bit_len;
          fill = fill - w.bit_len;
        end else begin
          window = '0;
          fill = '0;
        end
        r.accepted = 1'b1;
      end
      default: ;
    endcase
    r.bits_available = fill;
    r.overflowed = overflow_seen;
    r.source_end = end_marked && (fill == 7'd0);
    r.bytes_read = byte_total;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    lsbbr_pkg::result_t want;
    if (rst) begin
      big_endian = 1'b0;
      last_load_bits = 4'd0;
      window = '0;
      fill = '0;
      end_marked = 1'b0;
      overflow_seen = 1'b0;
      byte_total = '0;
      error_count = 0;
      expected_words.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          lsbbr_pkg::REG_BIG_ENDIAN: big_endian = cfg_data[0];
          lsbbr_pkg::REG_FINAL_BITS: last_load_bits = cfg_data;
          default: ;
        endcase
      end
      if (result_valid && !result_stall) begin
        if (expected_words.size() == 0) begin
          $display("%0t: result word with none expected, expected nothing, actual %h",
                   $time, result);
          error_count++;
        end else begin
          want = expected_words.pop_front();
          check_field("accepted", 32'(want.accepted), 32'(result.accepted));
          check_field("peek_value", 32'(want.peek_value), 32'(result.peek_value));
          check_field("short_of_bits", 32'(want.short_of_bits), 32'(result.short_of_bits));
          check_field("bits_available", 32'(want.bits_available),
                      32'(result.bits_available));
          check_field("overflowed", 32'(want.overflowed), 32'(result.overflowed));
          check_field("source_end", 32'(want.source_end), 32'(result.source_end));
          check_field("bytes_read", want.bytes_read, result.bytes_read);
        end
      end
      if (item_valid && !item_stall) begin
        advance_window(item, want);
        expected_words.push_back(want);
      end
    end
    words_due <= expected_words.size();
  end

endmodule

[bench/lsb_first_bit_reader_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsb_first_bit_reader_tb
// Drives directed and random feed, peek and shift words into the bit reader
// under several idling patterns, changes the mode between phases, and reports
// the verdict from the checker's error count.
// ----------------------------------------------------------------------------
module lsb_first_bit_reader_tb;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic       clk;
  logic       rst;
  logic       item_valid;
  logic       item_stall;
  lsbbr_pkg::item_t   item;
  logic       result_valid;
  logic       result_stall;
  lsbbr_pkg::result_t result;
  logic       cfg_write;
  logic       cfg_index;
  logic [3:0] cfg_data;
  int         error_count;
  int         words_due;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;

  lsb_first_bit_reader u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  bit_window_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .error_count  (error_count),
    .words_due    (words_due)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("lsb_first_bit_reader_tb: done, errors");
    $finish;
  end

  always @(negedge clk) begin
    result_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  function automatic lsbbr_pkg::item_t make_word(input logic [1:0] op,
                                                 input logic [15:0] data,
                                                 input logic last,
                                                 input logic [6:0] count);
    lsbbr_pkg::item_t w;
    w.operation = op;
    w.source_word = data;
    w.is_final_load = last;
    w.bit_len = count;
    return w;
  endfunction

  // Mostly small peeks and shifts, as a decoder front end would issue them,
  // with the occasional oversized count and unused operation.
  function automatic lsbbr_pkg::item_t random_word(input logic allow_last);
    int          pick;
    logic [1:0]  op;
    logic [6:0]  count;
    logic        last;
    pick = $urandom_range(99);
    if (pick < 40) begin
      op = lsbbr_pkg::OP_FEED;
    end else if (pick < 70) begin
      op = lsbbr_pkg::OP_PEEK;
    end else if (pick < 95) begin
      op = lsbbr_pkg::OP_SHIFT;
    end else begin
      op = OP_UNUSED;
    end
    if ($urandom_range(7) == 0) begin
      count = 7'($urandom_range(127));
    end else if (op == lsbbr_pkg::OP_PEEK) begin
      count = 7'($urandom_range(16));
    end else begin
      count = 7'($urandom_range(20));
    end
    last = allow_last ? ($urandom_range(9) == 0) : 1'b0;
    return make_word(op, 16'($urandom), last, count);
  endfunction

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_word(input lsbbr_pkg::item_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    item <= w;
    do @(posedge clk); while (item_stall);
    @(negedge clk);
  endtask

  task automatic settle();
    item_valid <= 1'b0;
    while (words_due != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_mode(input logic big_endian, input logic [3:0] last_bits);
    cfg_write <= 1'b1;
    cfg_index <= lsbbr_pkg::REG_BIG_ENDIAN;
    cfg_data <= {3'd0, big_endian};
    @(negedge clk);
    cfg_index <= lsbbr_pkg::REG_FINAL_BITS;
    cfg_data <= last_bits;
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    cfg_write = 1'b0;
    cfg_index = lsbbr_pkg::REG_BIG_ENDIAN;
    cfg_data = 4'd0;
    repeat (9) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // Byte mode: empty window, filling to the top, a refused feed, wide peeks.
    set_mode(1'b0, 4'd0);
    send_word(make_word(lsbbr_pkg::OP_PEEK, 16'h0000, 1'b0, 7'd0));
    send_word(make_word(lsbbr_pkg::OP_PEEK, 16'h0000, 1'b0, 7'd1));
    send_word(make_word(lsbbr_pkg::OP_SHIFT, 16'h0000, 1'b0, 7'd0));
    send_word(make_word(lsbbr_pkg::OP_FEED, 16'hFFFF, 1'b0, 7'd127));
    send_word(make_word(lsbbr_pkg::OP_FEED, 16'h0000, 1'b0, 7'd0));
    send_word(make_word(lsbbr_pkg::OP_FEED, 16'h5A3C, 1'b0, 7'd64));
    repeat (4) send_word(make_word(lsbbr_pkg::OP_FEED, 16'($urandom), 1'b0, 7'd0));
    send_word(make_word(lsbbr_pkg::OP_FEED, 16'h0081, 1'b0, 7'd0));
    send_word(make_word(lsbbr_pkg::OP_FEED, 16'h00FF, 1'b0, 7'd0));
    send_word(make_word(lsbbr_pkg::OP_PEEK, 16'h0000, 1'b0, 7'd16));
    send_word(make_word(lsbbr_pkg::OP_PEEK, 16'h0000, 1'b0, 7'd17));
    send_word(make_word(lsbbr_pkg::OP_PEEK, 16'h0000, 1'b0, 7'd64));
    send_word(make_word(lsbbr_pkg::OP_PEEK, 16'h0000, 1'b0, 7'd127));
    send_word(make_word(OP_UNUSED, 16'hFFFF, 1'b1, 7'd127));
    send_word(make_word(lsbbr_pkg::OP_SHIFT, 16'h0000, 1'b0, 7'd3));
    send_word(make_word(lsbbr_pkg::OP_SHIFT, 16'h0000, 1'b0, 7'd64));
    settle();

    // Word mode: bit-reversed 16-bit feeds up to a full window.
    set_mode(1'b1, 4'd15);
    send_word(make_word(lsbbr_pkg::OP_FEED, 16'h8001, 1'b0, 7'd0));
    send_word(make_word(lsbbr_pkg::OP_FEED, 16'hFFFF, 1'b0, 7'd0));
    send_word(make_word(lsbbr_pkg::OP_FEED, 16'h1234, 1'b0, 7'd0));
    send_word(make_word(lsbbr_pkg::OP_FEED, 16'h0F0F, 1'b0, 7'd0));
    send_word(make_word(lsbbr_pkg::OP_FEED, 16'hA5A5, 1'b0, 7'd0));
    send_word(make_word(lsbbr_pkg::OP_PEEK, 16'h0000, 1'b0, 7'd16));
    send_word(make_word(lsbbr_pkg::OP_SHIFT, 16'h0000, 1'b0, 7'd127));
    send_word(make_word(lsbbr_pkg::OP_PEEK, 16'h0000, 1'b0, 7'd5));

    for (int phase = 0; phase < 4; phase++) begin
      settle();
      case (phase)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
          set_mode(1'b0, 4'd15);
        end
        1: begin
          send_idle_pct = 47;
          recv_stall_pct = 0;
          set_mode(1'b1, 4'd0);
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 47;
          set_mode(1'b0, 4'($urandom_range(15)));
        end
        default: begin
          send_idle_pct = 35;
          recv_stall_pct = 35;
          set_mode(1'b1, 4'd8);
        end
      endcase
      repeat (250) send_word(random_word(1'b0));
    end

    // End of stream: the final load may be trimmed, later feeds are refused and
    // short peeks raise the sticky overflow.
    settle();
    set_mode(1'($urandom_range(1)), 4'($urandom_range(15)));
    send_word(make_word(lsbbr_pkg::OP_FEED, 16'($urandom), 1'b1, 7'd0));
    send_word(make_word(lsbbr_pkg::OP_PEEK, 16'h0000, 1'b0, 7'd16));
    send_word(make_word(lsbbr_pkg::OP_PEEK, 16'h0000, 1'b0, 7'd127));
    send_word(make_word(lsbbr_pkg::OP_FEED, 16'h1111, 1'b0, 7'd0));
    send_word(make_word(lsbbr_pkg::OP_FEED, 16'h2222, 1'b1, 7'd0));
    send_word(make_word(lsbbr_pkg::OP_SHIFT, 16'h0000, 1'b0, 7'd127));
    send_word(make_word(lsbbr_pkg::OP_PEEK, 16'h0000, 1'b0, 7'd1));
    repeat (20) send_word(random_word(1'b1));
    settle();

    if (error_count == 0 && words_due == 0) begin
      $display("lsb_first_bit_reader_tb: done, clean");
    end else begin
      $display("lsb_first_bit_reader_tb: done, errors");
    end
    $finish;
  end

endmodule
